### hdl/mk_pkg.sv
// ============================================================================
// mk_pkg - shared types and constants for the Morse keyer
// Unit patterns, FIFO sizing, input kinds and the result word layout.
// ============================================================================
package mk_pkg;

    // Code FIFO sizing
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Input kinds (carried on tuser)
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_PUSH = 1'b1;

    // Unit patterns, sent from bit 7 downward
    localparam logic [7:0] PAT_DOT      = 8'hBF;
    localparam logic [7:0] PAT_DASH     = 8'hEF;
    localparam logic [7:0] PAT_GAP_DOT  = 8'h2F;
    localparam logic [7:0] PAT_GAP_DASH = 8'h3B;
    localparam logic [7:0] PAT_WORD     = 8'h0F;
    localparam logic [7:0] ALL_ONES     = 8'hFF;

    // One result word, packed from the highest bit down
    typedef struct packed {
        logic push_dropped;
        logic keying;
        logic key_bit;
    } t_result;

    // A pattern or code is used up when all zeros or all ones
    function automatic logic spent(input logic [7:0] v);
        spent = (v == 8'h00) || (v == ALL_ONES);
    endfunction

    // Shift left, keeping bit 0 (sticky LSB)
    function automatic logic [7:0] code_shl(input logic [7:0] v);
        code_shl = {v[6:0], v[0]};
    endfunction

endpackage

### hdl/mk_core.sv
// ============================================================================
// mk_core - keyer state, code FIFO and per-word next-state logic
// Computes the result of one word combinationally and commits state on i_en.
// ============================================================================
module mk_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_action,
    input  logic [7:0]          i_code_byte,
    output mk_pkg::t_result     o_result
);

    logic [7:0]               r_code;
    logic [7:0]               r_unit;
    logic [mk_pkg::CNT_W-1:0] r_count;
    logic [mk_pkg::PTR_W-1:0] r_rd_ptr;
    logic [mk_pkg::PTR_W-1:0] r_wr_ptr;
    logic [7:0]               r_fifo [mk_pkg::FIFO_DEPTH];

    logic [7:0]               n_code;
    logic [7:0]               n_unit;
    logic [mk_pkg::CNT_W-1:0] n_count;
    logic [mk_pkg::PTR_W-1:0] n_rd_ptr;
    logic [mk_pkg::PTR_W-1:0] n_wr_ptr;
    logic                     fifo_we;
    logic                     fifo_full;
    logic [7:0]               head;
    logic [7:0]               unit_sel;
    mk_pkg::t_result          res;

    assign fifo_full = (r_count == mk_pkg::CNT_W'(mk_pkg::FIFO_DEPTH));
    assign head      = r_fifo[r_rd_ptr];

    // Next state and result for one word
    always_comb begin
        n_code   = r_code;
        n_unit   = r_unit;
        n_count  = r_count;
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        fifo_we  = 1'b0;
        unit_sel = r_unit;
        res      = '0;
        if (i_action == mk_pkg::ACT_PUSH) begin
            if (fifo_full) begin
                res.push_dropped = 1'b1;
            end else begin
                fifo_we  = 1'b1;
                n_count  = r_count + 1'b1;
                n_wr_ptr = (r_wr_ptr == mk_pkg::PTR_W'(mk_pkg::FIFO_DEPTH - 1)) ?
                           '0 : r_wr_ptr + 1'b1;
            end
        end else if (mk_pkg::spent(r_unit) && mk_pkg::spent(r_code) &&
                     (r_count == '0)) begin
            // idle: nothing left to send
            n_code = 8'h00;
            n_unit = 8'h00;
        end else begin
            if (mk_pkg::spent(r_unit)) begin
                if (mk_pkg::spent(r_code)) begin
                    // load next byte with letter-gap prefix, or word space for 0xFF
                    n_count  = r_count - 1'b1;
                    n_rd_ptr = (r_rd_ptr == mk_pkg::PTR_W'(mk_pkg::FIFO_DEPTH - 1)) ?
                               '0 : r_rd_ptr + 1'b1;
                    if (head == mk_pkg::ALL_ONES) begin
                        unit_sel = mk_pkg::PAT_WORD;
                        n_code   = head;
                    end else begin
                        unit_sel = head[7] ? mk_pkg::PAT_GAP_DASH : mk_pkg::PAT_GAP_DOT;
                        n_code   = mk_pkg::code_shl(head);
                    end
                end else begin
                    unit_sel = r_code[7] ? mk_pkg::PAT_DASH : mk_pkg::PAT_DOT;
                    n_code   = mk_pkg::code_shl(r_code);
                end
            end
            res.key_bit = unit_sel[7];
            res.keying  = 1'b1;
            n_unit      = {unit_sel[6:0], 1'b1};
        end
    end

    assign o_result = res;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code   <= mk_pkg::ALL_ONES;
            r_unit   <= mk_pkg::ALL_ONES;
            r_count  <= '0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else if (i_en) begin
            r_code   <= n_code;
            r_unit   <= n_unit;
            r_count  <= n_count;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    // FIFO storage
    always_ff @(posedge i_clk) begin
        if (i_en && fifo_we) begin
            r_fifo[r_wr_ptr] <= i_code_byte;
        end
    end

endmodule

### hdl/morse_keyer.sv
// ============================================================================
// morse_keyer - Morse code keyer with a 16-entry code FIFO
// Input register, keyer core and output register on stream channels.
// ============================================================================
// Usage:
//   Slave channel: tuser[0] is the kind (0 = tick one time unit, 1 = push),
//   tdata[7:0] is the code byte used on a push (0xFF = word space).
//   Master channel: one word per accepted input word, tdata[0] = key_bit,
//   tdata[1] = keying, tdata[2] = push_dropped.
//   A push to a full FIFO is dropped and flagged; a tick with nothing left
//   to send reports keying = 0.
// Pipeline: the input register feeds the core, and the result register loads
//   the core result once the output side can advance.
//   Throughput: one word per cycle while m_axis_tready does not stall the
//   output; the keyer core updates its state once per word.
// Reset: synchronous active-low; clears both pipeline valids, FIFO count and
//   pointers, and sets the code and unit patterns to all ones.
// Stall: when m_axis_tready is low the result register holds and the input
//   register accepts one more word; s_axis_tready then drops until the
//   result is taken.
// ============================================================================
module morse_keyer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] key_bit, [1] keying, [2] push_dropped
);

    logic            r_in_valid;
    logic            r_in_action;
    logic [7:0]      r_in_byte;
    logic            r_out_valid;
    mk_pkg::t_result r_out;

    logic            advance;
    logic            core_en;
    mk_pkg::t_result core_res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign core_en       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser;
            r_in_byte   <= s_axis_tdata;
        end
    end

    mk_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (core_en),
        .i_action    (r_in_action),
        .i_code_byte (r_in_byte),
        .o_result    (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_en) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.push_dropped, r_out.keying, r_out.key_bit};

endmodule
